// File: sv/pcsdl_pkg.sv
package pcsdl_pkg;

    // List geometry.
    localparam int CLASSES   = 4;
    localparam int DEPTH     = 16;
    localparam int MEM_DEPTH = CLASSES * DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CLS_W     = (CLASSES > 1) ? $clog2(CLASSES) : 1;

    // Field widths of the transfer payloads.
    localparam int TIME_W   = 24;
    localparam int CLASS_FW = 2;
    localparam int COUNT_FW = 5;
    localparam int STATUS_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic                opcode;
        logic [CLASS_FW-1:0] class_index;
        logic [TIME_W-1:0]   end_time;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_FW-1:0] count_after;
        logic                head_valid;
        logic [TIME_W-1:0]   earliest_end;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_DEL_SCAN,
        S_DEL_MOVE,
        S_HEAD,
        S_DONE
    } seq_state_t;

    // Top level to sequencer.
    typedef struct packed {
        logic start;
        logic can_load;
    } seq_ctrl_t;

    // Sequencer to top level.
    typedef struct packed {
        logic ready;
        logic load;
    } seq_stat_t;

    // Flat store address of slot idx in the list of class cls.
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [CLS_W-1:0] cls,
                                                     input logic [CNT_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(cls) * 32'(DEPTH) + 32'(idx);
        return wide[ADDR_W-1:0];
    endfunction

endpackage

// File: sv/pcsdl_store.sv
module pcsdl_store (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [pcsdl_pkg::ADDR_W-1:0] wr_addr,
    input  logic [pcsdl_pkg::TIME_W-1:0] wr_data,
    input  logic [pcsdl_pkg::ADDR_W-1:0] rd_addr,
    output logic [pcsdl_pkg::TIME_W-1:0] rd_data
);
    import pcsdl_pkg::*;

    logic [TIME_W-1:0] mem [MEM_DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    // A read in the same cycle as a write to the same slot returns the old value.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/pcsdl_seq.sv
module pcsdl_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pcsdl_pkg::seq_ctrl_t         ctrl,
    input  pcsdl_pkg::item_t             item,
    output pcsdl_pkg::seq_stat_t         stat,
    output pcsdl_pkg::result_t           res,
    output logic                         wr_en,
    output logic [pcsdl_pkg::ADDR_W-1:0] wr_addr,
    output logic [pcsdl_pkg::TIME_W-1:0] wr_data,
    output logic [pcsdl_pkg::ADDR_W-1:0] rd_addr,
    input  logic [pcsdl_pkg::TIME_W-1:0] rd_data
);
    import pcsdl_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [CLS_W-1:0]    cls_reg, cls_next;
    logic [TIME_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic                dv_reg, dv_next;
    logic                ins_reg, ins_next;
    logic [TIME_W-1:0]   carry_reg, carry_next;
    logic [CNT_W-1:0]    drop_reg, drop_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]    counts_reg [CLASSES];

    logic             cnt_wr;
    logic             issue;
    logic             gt_hit;
    logic             eq_hit;
    logic             cls_ok;
    logic [CLS_W-1:0] cls_in;
    logic [31:0]      cls_wide;
    logic [31:0]      cnt_wide;

    // The shared compare unit: the entry just read against the item's time.
    assign gt_hit = rd_data > key_reg;
    assign eq_hit = rd_data == key_reg;

    assign cls_wide = 32'(item.class_index);
    assign cls_in   = cls_wide[CLS_W-1:0];
    assign cls_ok   = cls_wide < 32'(CLASSES);
    assign issue    = rd_idx_reg < n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int c = 0; c < CLASSES; c++)
            begin
                counts_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cnt_wr)
            begin
                counts_reg[cls_reg] <= n_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg    <= cls_next;
        key_reg    <= key_next;
        n_reg      <= n_next;
        rd_idx_reg <= rd_idx_next;
        pos_reg    <= pos_next;
        dv_reg     <= dv_next;
        ins_reg    <= ins_next;
        carry_reg  <= carry_next;
        drop_reg   <= drop_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cls_next    = cls_reg;
        key_next    = key_reg;
        n_next      = n_reg;
        rd_idx_next = rd_idx_reg;
        pos_next    = pos_reg;
        dv_next     = dv_reg;
        ins_next    = ins_reg;
        carry_next  = carry_reg;
        drop_next   = drop_reg;
        status_next = status_reg;
        cnt_wr      = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = entry_addr(cls_reg, '0);
        wr_data     = key_reg;
        rd_addr     = entry_addr(cls_reg, '0);
        stat.ready  = 1'b0;
        stat.load   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                stat.ready = 1'b1;
                if (ctrl.start)
                begin
                    cls_next    = cls_in;
                    key_next    = item.end_time;
                    rd_idx_next = '0;
                    dv_next     = 1'b0;
                    ins_next    = 1'b0;
                    drop_next   = '0;
                    status_next = STAT_DONE;
                    if (!cls_ok)
                    begin
                        n_next      = '0;
                        status_next = (item.opcode == OP_DELETE) ? STAT_NOT_FOUND : STAT_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        n_next = counts_reg[cls_in];
                        if (item.opcode == OP_DELETE)
                        begin
                            state_next = S_DEL_SCAN;
                        end
                        else if (32'(counts_reg[cls_in]) >= 32'(DEPTH))
                        begin
                            status_next = STAT_FULL;
                            state_next  = S_HEAD;
                        end
                        else
                        begin
                            state_next = S_INS_SCAN;
                        end
                    end
                end
            end

            // One pass: each entry read is written back one slot later once the
            // new time has gone in ahead of it.
            S_INS_SCAN:
            begin
                if (issue)
                begin
                    rd_addr     = entry_addr(cls_reg, rd_idx_reg);
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    pos_next    = rd_idx_reg;
                end
                dv_next = issue;
                if (dv_reg)
                begin
                    if (!ins_reg && gt_hit)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = entry_addr(cls_reg, pos_reg);
                        wr_data    = key_reg;
                        carry_next = rd_data;
                        ins_next   = 1'b1;
                    end
                    else if (ins_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = entry_addr(cls_reg, pos_reg);
                        wr_data    = carry_reg;
                        carry_next = rd_data;
                    end
                end
                else if (!issue)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = entry_addr(cls_reg, n_reg);
                    wr_data    = ins_reg ? carry_reg : key_reg;
                    n_next     = n_reg + CNT_W'(1);
                    cnt_wr     = 1'b1;
                    state_next = S_HEAD;
                end
            end

            S_DEL_SCAN:
            begin
                if (issue)
                begin
                    rd_addr     = entry_addr(cls_reg, rd_idx_reg);
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    pos_next    = rd_idx_reg;
                end
                dv_next = issue;
                if (dv_reg && eq_hit)
                begin
                    drop_next   = pos_reg + CNT_W'(1);
                    rd_idx_next = pos_reg + CNT_W'(1);
                    dv_next     = 1'b0;
                    state_next  = S_DEL_MOVE;
                end
                else if (!dv_reg && !issue)
                begin
                    status_next = STAT_NOT_FOUND;
                    state_next  = S_HEAD;
                end
            end

            S_DEL_MOVE:
            begin
                if (issue)
                begin
                    rd_addr     = entry_addr(cls_reg, rd_idx_reg);
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    pos_next    = rd_idx_reg;
                end
                dv_next = issue;
                if (dv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = entry_addr(cls_reg, pos_reg - drop_reg);
                    wr_data = rd_data;
                end
                else if (!issue)
                begin
                    n_next     = n_reg - drop_reg;
                    cnt_wr     = 1'b1;
                    state_next = S_HEAD;
                end
            end

            // The head slot is read here and stays on the read port through S_DONE.
            S_HEAD:
            begin
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (ctrl.can_load)
                begin
                    stat.load  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cnt_wide         = 32'(n_reg);
    assign res.status       = status_reg;
    assign res.count_after  = cnt_wide[COUNT_FW-1:0];
    assign res.head_valid   = n_reg != '0;
    assign res.earliest_end = (n_reg != '0) ? rd_data : '0;

endmodule

// File: sv/per_class_sorted_deadline_list_unit.sv
// Items are taken one at a time: the next one is taken only once the result has been
// loaded and the sequencer is back in idle. The store, walked one slot per cycle during
// the scans, limits how fast items go through. A stalled result holds the sequencer only
// once the following item has finished.
// Reset: rst_n clears list counts and control state at once; list slots are not cleared.
module per_class_sorted_deadline_list_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  pcsdl_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output pcsdl_pkg::result_t result
);
    import pcsdl_pkg::*;

    seq_ctrl_t         ctrl;
    seq_stat_t         stat;
    result_t           res;
    result_t           result_reg;
    logic              result_valid_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [TIME_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [TIME_W-1:0] rd_data;

    // The sequencer takes an item only from idle; every other state stalls the input.
    assign item_stall = !stat.ready;
    assign ctrl.start = item_valid && stat.ready;

    // The result register may be reloaded when it is empty or is being transferred out
    // this cycle, so a finished result never waits on a bubble.
    assign ctrl.can_load = !result_valid_reg || !result_stall;

    pcsdl_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .item    (item),
        .stat    (stat),
        .res     (res),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pcsdl_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (stat.load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.load)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: sv/pcsdl_checker.sv
module pcsdl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input pcsdl_pkg::item_t   item,
    input logic               result_valid,
    input logic               result_stall,
    input pcsdl_pkg::result_t result
);
    import pcsdl_pkg::*;

    // A stalled result holds its value until transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

    // The block stalls its input in the cycle after it takes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
    else $error("input not stalled after a transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == STAT_DONE || result.status == STAT_FULL ||
                          result.status == STAT_NOT_FOUND))
    else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.head_valid == (result.count_after != '0)))
    else $error("head flag disagrees with count");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.head_valid |-> result.earliest_end == '0)
    else $error("empty list reports a head time");

endmodule

bind per_class_sorted_deadline_list_unit pcsdl_checker u_checker (.*);
